[hdl/ssp_pkg.sv]
// Shared types, field layout and codes for the scene settle pass trigger.
`default_nettype none

package ssp_pkg;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int SQ_W       = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int STILL_W    = 31;
  localparam int REASON_W   = 3;
  localparam int TSTAMP_W   = 32;

  // Input tdata layout, lowest bit first
  localparam int IN_TIME_LSB = 0;
  localparam int IN_EDGE_BIT = 32;
  localparam int IN_X_LSB    = 33;
  localparam int IN_Y_LSB    = 49;
  localparam int IN_DATA_W   = 72;

  // Output tdata layout: measure, reason, still_ms, zero pad
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_PAD_W   = OUT_DATA_W - 1 - REASON_W - STILL_W;

  localparam logic [STILL_W-1:0] STILL_MAX = {STILL_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REARM_MS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_TOL = 2'd2;

  // Verdict codes
  localparam logic [REASON_W-1:0] RSN_EMPTY_ARMED = 3'd0;
  localparam logic [REASON_W-1:0] RSN_EMPTY_WAIT  = 3'd1;
  localparam logic [REASON_W-1:0] RSN_EDGE        = 3'd2;
  localparam logic [REASON_W-1:0] RSN_MOVING      = 3'd3;
  localparam logic [REASON_W-1:0] RSN_MEASURED    = 3'd4;
  localparam logic [REASON_W-1:0] RSN_SETTLING    = 3'd5;
  localparam logic [REASON_W-1:0] RSN_MEASURE     = 3'd6;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Probe handed from cell to cell: the new centroid, the squared distances
  // to the previous cell's stored entry, and the running match flag
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SQ_W-1:0]    sqx;
    logic [SQ_W-1:0]    sqy;
    logic               live;
    logic               hit;
  } probe_t;

  // Squared distance within squared tolerance
  function automatic logic is_near(input logic [SQ_W-1:0] sqx,
                                   input logic [SQ_W-1:0] sqy,
                                   input logic [SQ_W-1:0] tol2);
    logic [SQ_W:0] sum;
    sum = {1'b0, sqx} + {1'b0, sqy};
    return sum <= {1'b0, tol2};
  endfunction

endpackage

`default_nettype wire

[hdl/scene_settle_pass_trigger_core.sv]
// Top level of the scene settle pass trigger: sequencer, verdict and ports.
//
// Frames arrive as runs of centroid requests closed by tlast, or as a single
// request with tuser set for an empty view; every finished frame gives one
// result request with measure, a reason code and the still time. Each centroid
// is compared with the previous frame's centroids by a chain of MAX_PIECES
// cells, one cell per clock, and the block takes no new request until the
// centroid leaves the chain; the last centroid of a frame and an empty-view
// request then pass the emit state, which forms the verdict and waits while the
// output is full. Requests beyond MAX_PIECES in a frame skip the chain. A new
// request is taken while an earlier result still waits on the output. The stored
// centroids have no reset; the block never reads an entry it has not written.
`default_nettype none

module scene_settle_pass_trigger_core #(
  parameter int MAX_PIECES = 8,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssp_pkg::CFG_W-1:0]      cfg_wdata,
  // input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata: time_ms[31:0], touches_edge[32], centre_x[48:33], centre_y[64:49]
  input  wire logic [ssp_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: frame_empty[0]
  input  wire logic [0:0]                     in_tuser,
  input  wire logic                           in_tlast,
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // tdata: measure[0], reason[3:1], still_ms[34:4]
  output logic [ssp_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import ssp_pkg::*;

  localparam int PW = $clog2(MAX_PIECES + 1);
  localparam int CW = $clog2(MAX_PIECES + 2);
  localparam int TW = TIME_WIDTH;

  // Configuration
  logic [CFG_W-1:0] rearm_r;
  logic [CFG_W-1:0] settle_r;
  logic [CFG_W-1:0] tol_r;
  logic [SQ_W-1:0]  tol2_r;

  // Control state
  state_t          state_r, state_nxt;
  logic            armed_r, armed_nxt;
  logic            had_prev_r, had_prev_nxt;
  logic            was_empty_r, was_empty_nxt;
  logic [TW-1:0]   still_since_r, still_since_nxt;
  logic [TW-1:0]   empty_since_r, empty_since_nxt;
  logic            bank_r, bank_nxt;
  logic [PW-1:0]   prev_cnt_r, prev_cnt_nxt;
  logic [CW-1:0]   cur_cnt_r, cur_cnt_nxt;
  logic            match_r, match_nxt;

  // Request held while it is worked on
  logic [TW-1:0]   t_r, t_nxt;
  logic            empty_r, empty_nxt;
  logic            edge_r, edge_nxt;
  logic            last_r, last_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Chain
  logic                  chain_v [MAX_PIECES+1];
  probe_t                chain_p [MAX_PIECES+1];
  logic [MAX_PIECES:0]   chain_vv;
  logic [MAX_PIECES-1:0] cell_live;
  logic [MAX_PIECES-1:0] cell_wr;

  // Request decode
  logic               in_fire;
  logic               in_empty;
  logic               launch;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic               hit_final;
  logic               emit_go;

  // Verdict arithmetic
  logic [TW-1:0]       empty_base;
  logic [TW-1:0]       still_diff;
  logic [STILL_W-1:0]  still_sat;
  logic                meas;
  logic [REASON_W-1:0] reason;
  logic [STILL_W-1:0]  still_out;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign in_empty  = in_tuser[0];
  assign in_x      = in_tdata[IN_X_LSB +: COORD_W];
  assign in_y      = in_tdata[IN_Y_LSB +: COORD_W];
  assign launch    = in_fire & ~in_empty & (cur_cnt_r < CW'(MAX_PIECES));

  // Configuration registers and squared tolerance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rearm_r  <= CFG_W'(500);
      settle_r <= CFG_W'(300);
      tol_r    <= CFG_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REARM_MS:  rearm_r  <= cfg_wdata;
        REG_SETTLE_MS: settle_r <= cfg_wdata;
        REG_STILL_TOL: tol_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tol2_r <= SQ_W'(tol_r) * SQ_W'(tol_r);
  end

  // Chain head: the new centroid with nothing to fold in yet
  assign chain_v[0]      = launch;
  assign chain_p[0].x    = in_x;
  assign chain_p[0].y    = in_y;
  assign chain_p[0].sqx  = '0;
  assign chain_p[0].sqy  = '0;
  assign chain_p[0].live = 1'b0;
  assign chain_p[0].hit  = 1'b0;

  for (genvar i = 0; i < MAX_PIECES; i++) begin : g_cell
    assign cell_live[i] = (prev_cnt_r > PW'(i));
    assign cell_wr[i]   = launch & (cur_cnt_r == CW'(i));

    ssp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tol2      (tol2_r),
      .bank_sel  (bank_r),
      .live      (cell_live[i]),
      .wr_en     (cell_wr[i]),
      .wr_bank   (~bank_r),
      .wr_x      (in_x),
      .wr_y      (in_y),
      .in_valid  (chain_v[i]),
      .in_probe  (chain_p[i]),
      .out_valid (chain_v[i+1]),
      .out_probe (chain_p[i+1])
    );
  end

  for (genvar i = 0; i <= MAX_PIECES; i++) begin : g_vv
    assign chain_vv[i] = chain_v[i];
  end

  // Chain tail: fold in the last cell's distance
  assign hit_final = chain_p[MAX_PIECES].hit |
                     (chain_p[MAX_PIECES].live &
                      is_near(chain_p[MAX_PIECES].sqx, chain_p[MAX_PIECES].sqy, tol2_r));

  // Time arithmetic for the verdict
  assign empty_base = was_empty_r ? empty_since_r : t_r;
  assign still_diff = t_r - still_since_r;
  assign still_sat  = (64'(still_diff) > 64'(STILL_MAX)) ? STILL_MAX : STILL_W'(still_diff);
  assign emit_go    = ~out_valid_r | out_tready;

  // Sequencer, frame bookkeeping and verdict
  always_comb begin
    state_nxt       = state_r;
    armed_nxt       = armed_r;
    had_prev_nxt    = had_prev_r;
    was_empty_nxt   = was_empty_r;
    still_since_nxt = still_since_r;
    empty_since_nxt = empty_since_r;
    bank_nxt        = bank_r;
    prev_cnt_nxt    = prev_cnt_r;
    cur_cnt_nxt     = cur_cnt_r;
    match_nxt       = match_r;
    t_nxt           = t_r;
    empty_nxt       = empty_r;
    edge_nxt        = edge_r;
    last_nxt        = last_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    out_data_nxt    = out_data_r;
    meas            = 1'b0;
    reason          = RSN_MOVING;
    still_out       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          t_nxt     = TW'(in_tdata[IN_TIME_LSB +: TSTAMP_W]);
          empty_nxt = in_empty;
          edge_nxt  = in_tdata[IN_EDGE_BIT];
          last_nxt  = in_tlast;
          if (in_empty) begin
            state_nxt = ST_EMIT;
          end else if (launch) begin
            cur_cnt_nxt = cur_cnt_r + CW'(1);
            state_nxt   = ST_SCAN;
          end else begin
            // too many centroids: frame can no longer be still
            cur_cnt_nxt = CW'(MAX_PIECES + 1);
            match_nxt   = 1'b0;
            state_nxt   = in_tlast ? ST_EMIT : ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        if (chain_v[MAX_PIECES]) begin
          match_nxt = match_r & hit_final;
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (emit_go) begin
          if (empty_r) begin
            was_empty_nxt   = 1'b1;
            empty_since_nxt = empty_base;
            had_prev_nxt    = 1'b0;
            prev_cnt_nxt    = '0;
            still_since_nxt = '0;
            if (!armed_r && ((t_r - empty_base) >= TW'(rearm_r))) begin
              armed_nxt = 1'b1;
            end
            reason = armed_nxt ? RSN_EMPTY_ARMED : RSN_EMPTY_WAIT;
          end else begin
            was_empty_nxt = 1'b0;
            if (edge_r) begin
              had_prev_nxt    = 1'b0;
              prev_cnt_nxt    = '0;
              still_since_nxt = '0;
              reason          = RSN_EDGE;
            end else if (cur_cnt_r > CW'(MAX_PIECES)) begin
              had_prev_nxt    = 1'b0;
              prev_cnt_nxt    = '0;
              still_since_nxt = t_r;
              reason          = RSN_MOVING;
            end else if (!had_prev_r || (cur_cnt_r != CW'(prev_cnt_r)) || !match_r) begin
              had_prev_nxt    = 1'b1;
              bank_nxt        = ~bank_r;
              prev_cnt_nxt    = PW'(cur_cnt_r);
              still_since_nxt = t_r;
              reason          = RSN_MOVING;
            end else begin
              bank_nxt     = ~bank_r;
              prev_cnt_nxt = PW'(cur_cnt_r);
              still_out    = still_sat;
              if (!armed_r) begin
                reason = RSN_MEASURED;
              end else if (still_sat < STILL_W'(settle_r)) begin
                reason = RSN_SETTLING;
              end else begin
                armed_nxt = 1'b0;
                meas      = 1'b1;
                reason    = RSN_MEASURE;
              end
            end
          end
          // open a new frame
          cur_cnt_nxt   = '0;
          match_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, still_out, reason, meas};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      armed_r       <= 1'b1;
      had_prev_r    <= 1'b0;
      was_empty_r   <= 1'b0;
      still_since_r <= '0;
      empty_since_r <= '0;
      bank_r        <= 1'b0;
      prev_cnt_r    <= '0;
      cur_cnt_r     <= '0;
      match_r       <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      armed_r       <= armed_nxt;
      had_prev_r    <= had_prev_nxt;
      was_empty_r   <= was_empty_nxt;
      still_since_r <= still_since_nxt;
      empty_since_r <= empty_since_nxt;
      bank_r        <= bank_nxt;
      prev_cnt_r    <= prev_cnt_nxt;
      cur_cnt_r     <= cur_cnt_nxt;
      match_r       <= match_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    empty_r    <= empty_nxt;
    edge_r     <= edge_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vv))
    else $error("more than one centroid in the comparison chain");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain_v[MAX_PIECES] |-> (state_r == ST_SCAN))
    else $error("chain tail valid outside scan");

  a_prev_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    prev_cnt_r <= PW'(MAX_PIECES))
    else $error("stored frame count exceeds capacity");

  a_measure_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && emit_go && meas) |=> (!armed_r && out_valid_r))
    else $error("measure verdict did not disarm the trigger");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !emit_go) |=> (state_r == ST_EMIT && out_valid_r))
    else $error("verdict lost while output stalled");

endmodule

`default_nettype wire

[hdl/ssp_cell.sv]
// One cell of the comparison chain: a stored centroid pair (two banks).
`default_nettype none

module ssp_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [ssp_pkg::SQ_W-1:0]    tol2,
  input  wire logic                        bank_sel,
  input  wire logic                        live,
  input  wire logic                        wr_en,
  input  wire logic                        wr_bank,
  input  wire logic [ssp_pkg::COORD_W-1:0] wr_x,
  input  wire logic [ssp_pkg::COORD_W-1:0] wr_y,
  input  wire logic                        in_valid,
  input  wire ssp_pkg::probe_t             in_probe,
  output logic                             out_valid,
  output ssp_pkg::probe_t                  out_probe
);
  import ssp_pkg::*;

  logic [COORD_W-1:0] store_x_r [2];
  logic [COORD_W-1:0] store_y_r [2];
  logic               valid_r;
  probe_t             probe_r;
  probe_t             probe_nxt;
  logic [COORD_W-1:0] sx;
  logic [COORD_W-1:0] sy;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;

  // Entry store, written for the bank not being compared against
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_x_r[wr_bank] <= wr_x;
      store_y_r[wr_bank] <= wr_y;
    end
  end

  // Fold in the previous cell's distance, square against this cell's entry
  always_comb begin
    sx = store_x_r[bank_sel];
    sy = store_y_r[bank_sel];
    dx = (in_probe.x > sx) ? in_probe.x - sx : sx - in_probe.x;
    dy = (in_probe.y > sy) ? in_probe.y - sy : sy - in_probe.y;
    probe_nxt.x    = in_probe.x;
    probe_nxt.y    = in_probe.y;
    probe_nxt.sqx  = SQ_W'(dx) * SQ_W'(dx);
    probe_nxt.sqy  = SQ_W'(dy) * SQ_W'(dy);
    probe_nxt.live = live;
    probe_nxt.hit  = in_probe.hit |
                     (in_probe.live & is_near(in_probe.sqx, in_probe.sqy, tol2));
  end

  // Hand-over register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
  end

  assign out_valid = valid_r;
  assign out_probe = probe_r;

endmodule

`default_nettype wire

[tb/scene_settle_pass_trigger_core_test.sv]
// Self-checking testbench for the scene settle pass trigger: directed table, then random frames.
`timescale 1ns / 1ps

module scene_settle_pass_trigger_core_test;
  import ssp_pkg::*;

  localparam int PIECES       = 8;
  localparam int PHASE_ITEMS  = 270;
  localparam int SETTLE_WAIT  = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                measure;
    logic [REASON_W-1:0] reason;
    logic [STILL_W-1:0]  still_ms;
  } verdict_t;

  // one row of the directed table; typed verdict used only where fixed is set
  typedef struct {
    logic [31:0] stamp;
    bit          empty;
    bit          touch;
    logic [15:0] cx;
    logic [15:0] cy;
    bit          last;
    bit          fixed;
    verdict_t    want;
  } plan_row_t;

  // DUT ports
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_REARM_MS;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [0:0]           in_tuser = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // typed verdict travelling with the request on the bus
  bit       row_fixed = 1'b0;
  verdict_t row_want = '0;

  // predictor copy of the configuration and state
  logic [15:0] rearm_set, settle_set, tol_set;
  bit          armed_q, had_prev_q, view_empty_q, frame_ok_q, bank_q;
  logic [31:0] still_since_q, empty_since_q;
  logic [15:0] keep_x [2*PIECES];
  logic [15:0] keep_y [2*PIECES];
  int unsigned prev_cnt_q, cur_cnt_q;

  verdict_t    verdicts_due[$];
  plan_row_t   plan[$];

  // bookkeeping
  int          faults = 0;
  int          stall_cycles = 0;
  int          requests_sent = 0;
  int          phase_items = 0;
  int          verdicts_checked = 0;
  int          reason_seen [8];
  bit          calm = 1'b0;

  // stimulus generator state
  logic [31:0] clock_ms = '0;
  int          gen_n = 0;
  logic [15:0] gen_x [PIECES];
  logic [15:0] gen_y [PIECES];
  logic [15:0] cur_x [16];
  logic [15:0] cur_y [16];

  scene_settle_pass_trigger_core #(
    .MAX_PIECES(PIECES),
    .TIME_WIDTH(32)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 8);
  end

  function automatic longint unsigned gap_sq(logic [15:0] a, logic [15:0] b);
    longint unsigned g;
    g = (a > b) ? a - b : b - a;
    return g * g;
  endfunction

  // Settle predictor: advances the state by one request, gives a verdict at frame end
  task automatic judge_item(input logic [31:0] stamp, input bit empty, input bit touch,
                            input logic [15:0] cx, input logic [15:0] cy, input bit last,
                            output bit made, output verdict_t v);
    logic [31:0]     gap;
    longint unsigned tol2;
    int unsigned     base, slot, i;
    bit              hit;
    made = 1'b0;
    v = '0;
    if (empty) begin
      // empty view is a whole frame; any partial frame is dropped
      cur_cnt_q = 0;
      frame_ok_q = 1'b1;
      if (!view_empty_q) begin
        view_empty_q = 1'b1;
        empty_since_q = stamp;
      end
      had_prev_q = 1'b0;
      prev_cnt_q = 0;
      still_since_q = '0;
      gap = stamp - empty_since_q;
      if (!armed_q && gap >= {16'd0, rearm_set}) armed_q = 1'b1;
      v.reason = armed_q ? RSN_EMPTY_ARMED : RSN_EMPTY_WAIT;
      made = 1'b1;
    end else begin
      if (cur_cnt_q < PIECES) begin
        base = bank_q ? PIECES : 0;
        slot = (bank_q ? 0 : PIECES) + cur_cnt_q;
        keep_x[slot] = cx;
        keep_y[slot] = cy;
        tol2 = {48'd0, tol_set};
        tol2 = tol2 * tol2;
        hit = 1'b0;
        for (i = 0; i < prev_cnt_q; i++) begin
          if (gap_sq(cx, keep_x[base + i]) + gap_sq(cy, keep_y[base + i]) <= tol2)
            hit = 1'b1;
        end
        if (!hit) frame_ok_q = 1'b0;
        cur_cnt_q++;
      end else begin
        cur_cnt_q = PIECES + 1;
        frame_ok_q = 1'b0;
      end
      if (last) begin
        view_empty_q = 1'b0;
        if (touch) begin
          had_prev_q = 1'b0;
          prev_cnt_q = 0;
          still_since_q = '0;
          v.reason = RSN_EDGE;
        end else if (cur_cnt_q > PIECES) begin
          had_prev_q = 1'b0;
          prev_cnt_q = 0;
          still_since_q = stamp;
          v.reason = RSN_MOVING;
        end else if (!had_prev_q || cur_cnt_q != prev_cnt_q || !frame_ok_q) begin
          had_prev_q = 1'b1;
          bank_q = ~bank_q;
          prev_cnt_q = cur_cnt_q;
          still_since_q = stamp;
          v.reason = RSN_MOVING;
        end else begin
          // still scene: saturate the elapsed time, then decide
          gap = stamp - still_since_q;
          bank_q = ~bank_q;
          prev_cnt_q = cur_cnt_q;
          v.still_ms = gap[31] ? STILL_MAX : gap[30:0];
          if (!armed_q) begin
            v.reason = RSN_MEASURED;
          end else if (v.still_ms < {15'd0, settle_set}) begin
            v.reason = RSN_SETTLING;
          end else begin
            armed_q = 1'b0;
            v.measure = 1'b1;
            v.reason = RSN_MEASURE;
          end
        end
        cur_cnt_q = 0;
        frame_ok_q = 1'b1;
        made = 1'b1;
      end
    end
  endtask

  task automatic note_fault(input string what, input verdict_t want, input verdict_t got);
    faults++;
    if (faults <= REPORT_LIMIT)
      $display({"[%0t] %s: want measure %0b reason %0d still %0d, ",
                "got measure %0b reason %0d still %0d"},
               $realtime, what, want.measure, want.reason, want.still_ms,
               got.measure, got.reason, got.still_ms);
  endtask

  // Checker, predictor hook and watchdog
  always @(posedge clk) begin
    verdict_t got, want, calc;
    bit       made;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.measure  = out_tdata[0];
        got.reason   = out_tdata[3:1];
        got.still_ms = out_tdata[34:4];
        verdicts_checked++;
        reason_seen[got.reason]++;
        if (verdicts_due.size() == 0) begin
          note_fault("result with nothing outstanding", '0, got);
        end else begin
          want = verdicts_due.pop_front();
          if (got.measure !== want.measure || got.reason !== want.reason ||
              got.still_ms !== want.still_ms)
            note_fault("verdict mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready) begin
        judge_item(in_tdata[31:0], in_tuser[0], in_tdata[IN_EDGE_BIT],
                   in_tdata[IN_X_LSB +: 16], in_tdata[IN_Y_LSB +: 16], in_tlast, made, calc);
        if (made) verdicts_due.push_back(row_fixed ? row_want : calc);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer, %0d verdicts outstanding",
                 stall_cycles, verdicts_due.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Drive one request; random sender gaps unless in the calm phase
  task automatic send_item(input logic [31:0] stamp, input bit empty, input bit touch,
                           input logic [15:0] cx, input logic [15:0] cy, input bit last,
                           input bit fixed, input verdict_t want);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, cy, cx, touch, stamp};
    in_tuser  <= empty;
    in_tlast  <= last;
    row_fixed <= fixed;
    row_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    phase_items++;
  endtask

  // Drain all verdicts, then let the block go quiet
  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] rearm, input logic [15:0] settle,
                              input logic [15:0] tol);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REARM_MS;
    cfg_wdata <= rearm;
    @(negedge clk);
    cfg_index <= REG_SETTLE_MS;
    cfg_wdata <= settle;
    @(negedge clk);
    cfg_index <= REG_STILL_TOL;
    cfg_wdata <= tol;
    @(negedge clk);
    cfg_we <= 1'b0;
    rearm_set  = rearm;
    settle_set = settle;
    tol_set    = tol;
  endtask

  function automatic logic [31:0] step_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 60);
    if (r < 90) return $urandom_range(100, 2000);
    if (r < 96) return $urandom_range(0, 70000);
    return $urandom;
  endfunction

  function automatic logic [15:0] clamp_coord(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Send cur_x/cur_y[0..n-1] as one frame; border flag only counts on the last request
  task automatic send_frame(input int n, input bit touch);
    int i;
    for (i = 0; i < n; i++) begin
      if (i == n - 1)
        send_item(clock_ms, 1'b0, touch, cur_x[i], cur_y[i], 1'b1, 1'b0, '0);
      else
        send_item($urandom, 1'b0, 1'($urandom_range(0, 1)), cur_x[i], cur_y[i], 1'b0,
                  1'b0, '0);
    end
    if (n <= PIECES) begin
      gen_n = n;
      for (i = 0; i < n; i++) begin
        gen_x[i] = cur_x[i];
        gen_y[i] = cur_y[i];
      end
    end
  endtask

  // One random frame: mostly a jittered copy of the previous one, the rest noise
  task automatic random_frame();
    int kind, n, i, j, rot, sel, dx, dy;
    kind = $urandom_range(0, 99);
    clock_ms = clock_ms + step_ms();
    if (kind < 55 && gen_n > 0 || kind >= 92 && gen_n > 0) begin
      n = gen_n;
      if (kind >= 92) n = (gen_n == 1 || (gen_n < PIECES && $urandom_range(0, 1))) ?
                          gen_n + 1 : gen_n - 1;
      sel = $urandom_range(0, 3);
      j = (sel == 0) ? 0 : (sel == 1) ? int'(tol_set) / 2 : (sel == 2) ? int'(tol_set) :
          int'(tol_set) + int'(tol_set) / 4 + 1;
      rot = $urandom_range(0, gen_n - 1);
      for (i = 0; i < n; i++) begin
        dx = $urandom_range(0, j);
        dy = $urandom_range(0, j);
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        cur_x[i] = clamp_coord(int'(gen_x[(i + rot) % gen_n]) + dx);
        cur_y[i] = clamp_coord(int'(gen_y[(i + rot) % gen_n]) + dy);
      end
      send_frame(n, $urandom_range(0, 99) < 3);
    end else if (kind < 65) begin
      // run of empty views, long enough at times to rearm
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        if (i > 0) clock_ms = clock_ms + step_ms();
        send_item(clock_ms, 1'b1, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end else if (kind < 85) begin
      // fresh frame, border frame or an oversized frame
      n = (kind < 80) ? $urandom_range(1, PIECES) : $urandom_range(PIECES + 1, PIECES + 4);
      for (i = 0; i < n; i++) begin
        cur_x[i] = 16'($urandom);
        cur_y[i] = 16'($urandom);
      end
      send_frame(n, kind >= 75 && kind < 80);
    end else begin
      // broken frame cut short by an empty view
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++)
        send_item($urandom, 1'b0, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                  1'b0, 1'b0, '0);
      send_item(clock_ms, 1'b1, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  function automatic verdict_t vd(bit measure, logic [REASON_W-1:0] reason,
                                  logic [STILL_W-1:0] still);
    verdict_t v;
    v.measure = measure;
    v.reason = reason;
    v.still_ms = still;
    return v;
  endfunction

  // Directed table, default settings: rearm 500, settle 300, tolerance 32
  task automatic build_plan();
    int i;
    plan.push_back('{32'd0,    1, 1, 16'hFFFF, 16'hFFFF, 0, 1, vd(0, RSN_EMPTY_ARMED, 0)});
    plan.push_back('{32'd10,   0, 1, 16'h0000, 16'h0000, 1, 1, vd(0, RSN_EDGE, 0)});
    plan.push_back('{32'd20,   0, 0, 16'hFFFF, 16'hFFFF, 1, 1, vd(0, RSN_MOVING, 0)});
    plan.push_back('{32'd100,  0, 0, 16'hFFFF, 16'hFFFF, 1, 0, '0});
    plan.push_back('{32'd400,  0, 0, 16'hFFFF, 16'hFFFF, 1, 0, '0});
    plan.push_back('{32'd500,  0, 0, 16'hFFFF, 16'hFFFF, 1, 0, '0});
    // moved by exactly the tolerance, then by one more
    plan.push_back('{32'd600,  0, 0, 16'hFFDF, 16'hFFFF, 1, 0, '0});
    plan.push_back('{32'd700,  0, 0, 16'hFFDF, 16'hFFDE, 1, 1, vd(0, RSN_MOVING, 0)});
    // border flag on a non-last request is ignored; count change means moving
    plan.push_back('{32'd710,  0, 1, 16'hFFDF, 16'hFFDE, 0, 0, '0});
    plan.push_back('{32'd720,  0, 0, 16'h1234, 16'h5678, 1, 0, '0});
    // disarmed: rearm needs the view empty for the full rearm time
    plan.push_back('{32'd1000, 1, 0, 16'h0000, 16'h0000, 0, 1, vd(0, RSN_EMPTY_WAIT, 0)});
    plan.push_back('{32'd1499, 1, 0, 16'h0000, 16'h0000, 1, 1, vd(0, RSN_EMPTY_WAIT, 0)});
    plan.push_back('{32'd1500, 1, 0, 16'h0000, 16'h0000, 1, 1, vd(0, RSN_EMPTY_ARMED, 0)});
    // partial frame dropped by an empty view
    plan.push_back('{32'd1600, 0, 0, 16'h8000, 16'h0001, 0, 0, '0});
    plan.push_back('{32'd1610, 1, 0, 16'h0000, 16'h0000, 0, 1, vd(0, RSN_EMPTY_ARMED, 0)});
    // one centroid too many
    for (i = 0; i < PIECES; i++)
      plan.push_back('{32'd2000, 0, 0, 16'(i * 16'h1F00), 16'(16'hFFFF - i), 0, 0, '0});
    plan.push_back('{32'd2000, 0, 0, 16'h7FFF, 16'h8000, 1, 1, vd(0, RSN_MOVING, 0)});
    // still time across the timestamp wrap, then saturated
    plan.push_back('{32'hFFFFFF00, 0, 0, 16'h0000, 16'h0000, 1, 0, '0});
    plan.push_back('{32'h00000100, 0, 0, 16'h0000, 16'h0000, 1, 0, '0});
    plan.push_back('{32'h90000000, 0, 0, 16'h0000, 16'h0000, 1, 0, '0});
  endtask

  initial begin
    int p;
    logic [15:0] rearm, settle, tol;
    // predictor reset state
    rearm_set = 16'd500;
    settle_set = 16'd300;
    tol_set = 16'd32;
    armed_q = 1'b1;
    had_prev_q = 1'b0;
    view_empty_q = 1'b0;
    frame_ok_q = 1'b1;
    bank_q = 1'b0;
    still_since_q = '0;
    empty_since_q = '0;
    prev_cnt_q = 0;
    cur_cnt_q = 0;
    foreach (reason_seen[k]) reason_seen[k] = 0;
    build_plan();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k])
      send_item(plan[k].stamp, plan[k].empty, plan[k].touch, plan[k].cx, plan[k].cy,
                plan[k].last, plan[k].fixed, plan[k].want);
    quiesce();

    // random phases over a spread of settings, extremes included
    for (p = 1; p <= 5; p++) begin
      case (p)
        1: begin rearm = 16'd0; settle = 16'd0; tol = 16'd0; end
        2: begin rearm = 16'hFFFF; settle = 16'hFFFF; tol = 16'hFFFF; end
        3: begin
          rearm = 16'($urandom_range(0, 2000));
          settle = 16'($urandom_range(0, 1500));
          tol = 16'($urandom_range(0, 200));
        end
        4: begin
          rearm = 16'($urandom);
          settle = 16'($urandom_range(0, 300));
          tol = 16'($urandom);
        end
        default: begin rearm = 16'd1; settle = 16'd1; tol = 16'd1; end
      endcase
      program_regs(rearm, settle, tol);
      calm = (p == 3);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) random_frame();
      quiesce();
      calm = 1'b0;
    end

    $display("summary: %0d requests over the directed table and 5 settings, %0d verdicts checked",
             requests_sent, verdicts_checked);
    $display({"verdicts: empty armed %0d, rearm pending %0d, edge %0d, moving %0d, ",
              "measured %0d, settling %0d, measure %0d"},
             reason_seen[RSN_EMPTY_ARMED], reason_seen[RSN_EMPTY_WAIT], reason_seen[RSN_EDGE],
             reason_seen[RSN_MOVING], reason_seen[RSN_MEASURED], reason_seen[RSN_SETTLING],
             reason_seen[RSN_MEASURE]);
    if (faults == 0 && verdicts_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ssp_pkg.sv
hdl/ssp_cell.sv
hdl/scene_settle_pass_trigger_core.sv
tb/scene_settle_pass_trigger_core_test.sv
